### rtl/hlc_pkg.sv
// Shared types and codes for the hashed LRU buffer cache.
// Used by the cell, the top level and the checker.
`default_nettype none
package hlc_pkg;
    localparam int DEF_POOL_ENTRIES = 32;
    localparam int DEF_BUCKET_COUNT = 13;
    localparam int MAX_IDX_W = 8;
    localparam int MAX_BKT_W = 6;
    localparam int BLK_W = 32;
    localparam int DEV_W = 8;
    localparam int CNT_W = 8;

    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PIN     = 2'd2;
    localparam logic [1:0] ACT_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [DEV_W-1:0]     dev;
        logic [BLK_W-1:0]     blk;
        logic [MAX_BKT_W-1:0] bk;
        logic [4:0]           idx;
    } t_req;

    typedef struct packed {
        logic                 hit_f;
        logic [MAX_IDX_W-1:0] hit_idx;
        logic [MAX_IDX_W-1:0] hit_rank;
        logic                 hit_full;
        logic                 hit_valid;
        logic                 own_f;
        logic [MAX_IDX_W-1:0] own_idx;
        logic [MAX_IDX_W-1:0] own_rank;
        logic                 oth_f;
        logic [MAX_IDX_W-1:0] oth_idx;
        logic [MAX_IDX_W-1:0] oth_rank;
        logic [MAX_BKT_W-1:0] oth_bkt;
        logic                 tgt_zero;
        logic                 tgt_one;
        logic                 tgt_full;
        logic [MAX_IDX_W-1:0] tgt_rank;
    } t_cand;

    typedef struct packed {
        logic                 en;
        logic [MAX_IDX_W-1:0] idx;
        logic                 write_tag;
        logic                 set_valid;
        logic                 inc;
        logic                 dec;
        logic                 recent;
        logic [MAX_IDX_W-1:0] old_rank;
        logic [DEV_W-1:0]     dev;
        logic [BLK_W-1:0]     blk;
        logic [MAX_BKT_W-1:0] bk;
    } t_upd;
endpackage
`default_nettype wire

### rtl/hlc_cell.sv
// One buffer entry of the cache and its stage of the candidate chain.
// Depends on hlc_pkg.
`default_nettype none
module hlc_cell import hlc_pkg::*; #(
    parameter int K = 0,
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_req  i_req,
    input  wire t_upd  i_upd,
    input  wire t_cand i_cand,
    output t_cand      o_cand
);
    localparam int RW = $clog2(POOL_ENTRIES);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(K);

    logic [DEV_W-1:0] r_dev;
    logic [BLK_W-1:0] r_blk;
    logic [BW-1:0]    r_bkt;
    logic             r_valid;
    logic [CNT_W-1:0] r_cnt;
    logic [RW-1:0]    r_rank;
    t_cand            r_cand, n_cand;

    logic [MAX_IDX_W-1:0] rank_x;
    logic [MAX_BKT_W-1:0] bkt_x;
    logic                 free_e, same_bkt, match_e;

    always_comb begin
        rank_x   = MAX_IDX_W'(r_rank);
        bkt_x    = MAX_BKT_W'(r_bkt);
        free_e   = (r_cnt == '0);
        same_bkt = (bkt_x == i_req.bk);
        match_e  = same_bkt && (r_dev == i_req.dev) && (r_blk == i_req.blk);
        n_cand   = i_cand;
        if (match_e && (!i_cand.hit_f || rank_x > i_cand.hit_rank)) begin
            n_cand.hit_f     = 1'b1;
            n_cand.hit_idx   = MY_IDX;
            n_cand.hit_rank  = rank_x;
            n_cand.hit_full  = (r_cnt == {CNT_W{1'b1}});
            n_cand.hit_valid = r_valid;
        end
        if (free_e && same_bkt && (!i_cand.own_f || rank_x < i_cand.own_rank)) begin
            n_cand.own_f    = 1'b1;
            n_cand.own_idx  = MY_IDX;
            n_cand.own_rank = rank_x;
        end
        if (free_e && !same_bkt && (!i_cand.oth_f || bkt_x < i_cand.oth_bkt ||
                (bkt_x == i_cand.oth_bkt && rank_x < i_cand.oth_rank))) begin
            n_cand.oth_f    = 1'b1;
            n_cand.oth_idx  = MY_IDX;
            n_cand.oth_rank = rank_x;
            n_cand.oth_bkt  = bkt_x;
        end
        if (MAX_IDX_W'(i_req.idx) == MY_IDX) begin
            n_cand.tgt_zero = free_e;
            n_cand.tgt_one  = (r_cnt == CNT_W'(1));
            n_cand.tgt_full = (r_cnt == {CNT_W{1'b1}});
            n_cand.tgt_rank = rank_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (!i_rst_n) begin
            r_dev   <= '0;
            r_blk   <= '0;
            r_bkt   <= '0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_rank  <= RW'(K);
        end else if (i_upd.en) begin
            if (i_upd.idx == MY_IDX) begin
                if (i_upd.write_tag) begin
                    r_dev   <= i_upd.dev;
                    r_blk   <= i_upd.blk;
                    r_bkt   <= i_upd.bk[BW-1:0];
                    r_valid <= 1'b1;
                    r_cnt   <= CNT_W'(1);
                end else begin
                    if (i_upd.set_valid) r_valid <= 1'b1;
                    if (i_upd.inc) r_cnt <= r_cnt + CNT_W'(1);
                    if (i_upd.dec) r_cnt <= r_cnt - CNT_W'(1);
                end
                if (i_upd.recent) r_rank <= RW'(POOL_ENTRIES - 1);
            end else if (i_upd.recent && rank_x > i_upd.old_rank) begin
                r_rank <= r_rank - RW'(1);
            end
        end
    end

    assign o_cand = r_cand;
endmodule
`default_nettype wire

### rtl/hashed_lru_block_buffer_cache.sv
// Top level of the hashed LRU buffer cache: sequencer, bucket hash unit and
// the chain of entry cells. Depends on hlc_pkg and hlc_cell.
`default_nettype none
// Usage
// The request channel (i_valid/i_ready) carries an action, a device, a block
// number and a buffer index. The result channel (o_valid/o_ready) returns one
// transfer per request: the granted index, the need-fill flag and a status.
// The block works on one request at a time. A read first reduces its block
// number to a bucket: the bytes are summed, each weighted by its
// power-of-256 residue, the sum is multiplied by a scaled reciprocal of the
// bucket count to get the quotient, and the quotient multiple is taken off
// the sum. Then every request lets the candidate records ripple down the
// chain of POOL_ENTRIES cells, one cell per cycle, each cell folding in its
// own entry (tag hit, least recent free entry of the bucket, best free entry
// of another bucket, and the addressed entry's count). The apply state then
// updates all cells at once with the choice and loads the output register.
// The next request is taken in the cycle after the result transfer.
// Reset clears every entry, sets entry k to recency rank k and empties the
// output register. A stalled receiver simply holds the result in place; no
// new request is taken until it has been transferred.
module hashed_lru_block_buffer_cache import hlc_pkg::*; #(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             i_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_device,
    input  wire logic [31:0] i_block_number,
    input  wire logic [4:0]  i_buffer_index,
    output logic             o_valid,
    input  wire logic        o_ready,
    output logic [4:0]       o_granted_index,
    output logic             o_need_fill,
    output logic [1:0]       o_status
);
    localparam int SW = $clog2(POOL_ENTRIES + 1);
    // Residues of 2^0, 2^8, 2^16 and 2^24 modulo the bucket count.
    localparam logic [5:0]  W0 = 6'(1 % BUCKET_COUNT);
    localparam logic [5:0]  W1 = 6'((1 << 8) % BUCKET_COUNT);
    localparam logic [5:0]  W2 = 6'((1 << 16) % BUCKET_COUNT);
    localparam logic [5:0]  W3 = 6'((1 << 24) % BUCKET_COUNT);
    // Reciprocal scaled by 2^23, rounded up; exact for any 16-bit sum.
    localparam logic [23:0] RECIP = 24'(((1 << 23) + BUCKET_COUNT - 1) / BUCKET_COUNT);
    localparam logic [6:0]  BCONST = 7'(BUCKET_COUNT);

    typedef enum logic [2:0] {S_IDLE, S_HASH, S_SCAN, S_APPLY, S_OUT} t_state;

    t_state      r_state;
    t_req        r_req;
    logic [1:0]  r_bit;
    logic [15:0] r_sum;
    logic [15:0] r_quo;
    logic [SW-1:0] r_scan;
    t_upd        upd;
    t_cand       chain [POOL_ENTRIES+1];
    logic [15:0] hsum;
    logic [39:0] hprod;
    logic [22:0] hqb;
    logic [15:0] hrem;
    logic [4:0]  res_idx;
    logic        res_fill;
    logic [1:0]  res_st;
    logic [MAX_IDX_W+4:0] idx_wide;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < POOL_ENTRIES; g++) begin : g_cell
            hlc_cell #(.K(g), .POOL_ENTRIES(POOL_ENTRIES),
                       .BUCKET_COUNT(BUCKET_COUNT)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_req  (r_req),
                .i_upd  (upd),
                .i_cand (chain[g]),
                .o_cand (chain[g+1])
            );
        end
    endgenerate

    // Bucket reduction: weighted byte sum, reciprocal quotient, remainder.
    always_comb begin
        hsum  = 16'({6'd0, r_req.blk[7:0]}   * {8'd0, W0}) +
                16'({6'd0, r_req.blk[15:8]}  * {8'd0, W1}) +
                16'({6'd0, r_req.blk[23:16]} * {8'd0, W2}) +
                16'({6'd0, r_req.blk[31:24]} * {8'd0, W3});
        hprod = {24'd0, r_sum} * {16'd0, RECIP};
        hqb   = {7'd0, r_quo} * {16'd0, BCONST};
        hrem  = r_sum - hqb[15:0];
    end

    // Decision on the settled chain output.
    always_comb begin
        t_cand c;
        c        = chain[POOL_ENTRIES];
        upd      = '0;
        upd.dev  = r_req.dev;
        upd.blk  = r_req.blk;
        upd.bk   = r_req.bk;
        res_fill = 1'b0;
        res_st   = ST_OK;
        idx_wide = '0;
        if (r_req.action == ACT_READ) begin
            if (c.hit_f) begin
                idx_wide      = (MAX_IDX_W+5)'(c.hit_idx);
                upd.idx       = c.hit_idx;
                upd.set_valid = 1'b1;
                upd.inc       = !c.hit_full;
                res_st        = c.hit_full ? ST_OVER : ST_OK;
                res_fill      = !c.hit_valid;
                upd.en        = 1'b1;
            end else if (c.own_f) begin
                idx_wide      = (MAX_IDX_W+5)'(c.own_idx);
                upd.idx       = c.own_idx;
                upd.write_tag = 1'b1;
                res_fill      = 1'b1;
                upd.en        = 1'b1;
            end else if (c.oth_f) begin
                idx_wide      = (MAX_IDX_W+5)'(c.oth_idx);
                upd.idx       = c.oth_idx;
                upd.write_tag = 1'b1;
                upd.recent    = 1'b1;
                upd.old_rank  = c.oth_rank;
                res_fill      = 1'b1;
                upd.en        = 1'b1;
            end else begin
                res_st = ST_NOFREE;
            end
        end else begin
            idx_wide = (MAX_IDX_W+5)'(r_req.idx);
            upd.idx  = MAX_IDX_W'(r_req.idx);
            // Indexes beyond the pool leave every entry untouched.
            if ((MAX_IDX_W+1)'(r_req.idx) < (MAX_IDX_W+1)'(POOL_ENTRIES)) begin
                if (r_req.action == ACT_PIN) begin
                    if (c.tgt_full) res_st = ST_OVER;
                    else upd.inc = 1'b1;
                end else if (c.tgt_zero) begin
                    res_st = ST_UNDER;
                end else begin
                    upd.dec = 1'b1;
                    if (r_req.action == ACT_RELEASE && c.tgt_one) begin
                        upd.recent   = 1'b1;
                        upd.old_rank = c.tgt_rank;
                    end
                end
                upd.en = 1'b1;
            end
        end
        res_idx = idx_wide[4:0];
        if (r_state != S_APPLY) upd.en = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req.action <= i_action;
                        r_req.dev    <= i_device;
                        r_req.blk    <= i_block_number;
                        r_req.idx    <= i_buffer_index;
                        r_req.bk     <= '0;
                        r_bit        <= '0;
                        r_scan       <= '0;
                        r_state      <= (i_action == ACT_READ) ? S_HASH : S_SCAN;
                    end
                end
                S_HASH: begin
                    r_bit <= r_bit + 2'd1;
                    if (r_bit == 2'd0) r_sum <= hsum;
                    if (r_bit == 2'd1) r_quo <= hprod[38:23];
                    if (r_bit == 2'd2) begin
                        r_req.bk <= hrem[MAX_BKT_W-1:0];
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + SW'(1);
                    if (r_scan == SW'(POOL_ENTRIES - 1)) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    o_granted_index <= res_idx;
                    o_need_fill     <= res_fill;
                    o_status        <= res_st;
                    o_valid         <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (o_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

### rtl/hlc_checker.sv
// Port-level checks for the hashed LRU buffer cache, bound to the top level.
// Depends on hlc_pkg.
`default_nettype none
module hlc_checker import hlc_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic       o_valid,
    input wire logic       o_ready,
    input wire logic [4:0] o_granted_index,
    input wire logic       o_need_fill,
    input wire logic [1:0] o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_granted_index) &&
        $stable(o_need_fill) && $stable(o_status))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !i_ready)
        else $error("request taken while a result is pending");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |=> !o_valid)
        else $error("result appeared too early");
    a_nofree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NOFREE |-> o_granted_index == 5'd0 && !o_need_fill)
        else $error("no-free result carries an entry");
endmodule

bind hashed_lru_block_buffer_cache hlc_checker u_hlc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready(i_ready),
    .o_valid(o_valid), .o_ready(o_ready), .o_granted_index(o_granted_index),
    .o_need_fill(o_need_fill), .o_status(o_status)
);
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for hashed_lru_block_buffer_cache: a stimulus table and random traffic.
// Each result is compared with an in-bench predictor of the buffer pool. Depends on hlc_pkg.
module tb_top import hlc_pkg::*; ();

    localparam int NPOOL = 32;
    localparam int NBKT  = 13;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready;
    logic [1:0]  i_action = ACT_READ;
    logic [7:0]  i_device = '0;
    logic [31:0] i_block_number = '0;
    logic [4:0]  i_buffer_index = '0;
    logic        o_valid;
    logic        o_ready = 1'b0;
    logic [4:0]  o_granted_index;
    logic        o_need_fill;
    logic [1:0]  o_status;

    hashed_lru_block_buffer_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready(i_ready),
        .i_action(i_action), .i_device(i_device), .i_block_number(i_block_number),
        .i_buffer_index(i_buffer_index), .o_valid(o_valid), .o_ready(o_ready),
        .o_granted_index(o_granted_index), .o_need_fill(o_need_fill), .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the pool that the bench predicts from.
    logic [7:0]  pool_dev  [NPOOL];
    logic [31:0] pool_blk  [NPOOL];
    logic        pool_val  [NPOOL];
    logic [7:0]  pool_cnt  [NPOOL];
    int          pool_rank [NPOOL];

    typedef struct packed {
        logic [4:0] gidx;
        logic       fill;
        logic [1:0] stat;
    } t_grant;

    t_grant grant_q[$];
    int     mismatches = 0;
    bit     sender_done = 1'b0;
    bit     hold_off = 1'b0;
    bit     quiet = 1'b0;

    // Rows of the directed table; chk marks a row whose result is typed in.
    typedef struct {
        logic [1:0]  act;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  idx;
        bit          chk;
        t_grant      want;
    } t_row;

    function automatic void touch_recent(int e);
        int r;
        r = pool_rank[e];
        for (int k = 0; k < NPOOL; k++)
            if (pool_rank[k] > r) pool_rank[k]--;
        pool_rank[e] = NPOOL - 1;
    endfunction

    function automatic int oldest_free_in(int bk);
        int best;
        best = -1;
        for (int k = 0; k < NPOOL; k++)
            if (pool_blk[k] % NBKT == bk && pool_cnt[k] == 0 &&
                (best < 0 || pool_rank[k] < pool_rank[best])) best = k;
        return best;
    endfunction

    // Applies one request to the shadow pool and returns the grant it yields.
    function automatic t_grant predict_grant(logic [1:0] act, logic [7:0] dev,
                                             logic [31:0] blk, logic [4:0] idx);
        t_grant g;
        int bk, e;
        bit stolen;
        g = '{gidx: '0, fill: 1'b0, stat: ST_OK};
        if (act == ACT_READ) begin
            bk = blk % NBKT;
            e = -1;
            stolen = 1'b0;
            for (int k = 0; k < NPOOL; k++)
                if (pool_dev[k] == dev && pool_blk[k] == blk &&
                    (e < 0 || pool_rank[k] > pool_rank[e])) e = k;
            if (e >= 0) begin
                if (pool_cnt[e] == 8'd255) g.stat = ST_OVER;
                else pool_cnt[e]++;
            end else begin
                e = oldest_free_in(bk);
                if (e < 0) begin
                    for (int k = 0; k < NBKT && e < 0; k++)
                        if (k != bk) e = oldest_free_in(k);
                    stolen = (e >= 0);
                end
                if (e >= 0) begin
                    pool_dev[e] = dev;
                    pool_blk[e] = blk;
                    pool_val[e] = 1'b0;
                    pool_cnt[e] = 8'd1;
                    if (stolen) touch_recent(e);
                end
            end
            if (e < 0) g.stat = ST_NOFREE;
            else begin
                g.gidx = e[4:0];
                g.fill = !pool_val[e];
                pool_val[e] = 1'b1;
            end
        end else begin
            g.gidx = idx;
            if (act == ACT_PIN) begin
                if (pool_cnt[idx] == 8'd255) g.stat = ST_OVER;
                else pool_cnt[idx]++;
            end else if (pool_cnt[idx] == 8'd0) g.stat = ST_UNDER;
            else begin
                pool_cnt[idx]--;
                if (act == ACT_RELEASE && pool_cnt[idx] == 8'd0) touch_recent(idx);
            end
        end
        return g;
    endfunction

    // Offers one request and waits for its transfer, then records the expected grant.
    task automatic offer(logic [1:0] act, logic [7:0] dev, logic [31:0] blk,
                         logic [4:0] idx, bit chk, t_grant want);
        t_grant g;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_device       <= dev;
        i_block_number <= blk;
        i_buffer_index <= idx;
        @(posedge i_clk);
        while (!i_ready) @(posedge i_clk);
        g = predict_grant(act, dev, blk, idx);
        if (chk && g != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: row %p, predicted %p", want, g);
        end
        grant_q.push_back(g);
    endtask

    // Blocks mostly small, some random or near 2^32, so hits, recycling and steals all occur.
    function automatic logic [31:0] pick_block();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(12);
            default: return $urandom_range(40);
        endcase
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        int   held[$];
        int   p;
        for (int k = 0; k < NPOOL; k++) begin
            pool_dev[k] = '0; pool_blk[k] = '0; pool_val[k] = 1'b0;
            pool_cnt[k] = '0; pool_rank[k] = k;
        end
        // After reset every entry tags device 0 block 0, so the most recent one, 31, hits.
        rows.push_back('{ACT_READ, 8'd0, 32'd0, 5'd0, 1, '{5'd31, 1'b1, ST_OK}});
        rows.push_back('{ACT_READ, 8'd0, 32'd0, 5'd0, 1, '{5'd31, 1'b0, ST_OK}});
        rows.push_back('{ACT_UNPIN, 8'd0, 32'd0, 5'd3, 1, '{5'd3, 1'b0, ST_UNDER}});
        rows.push_back('{ACT_RELEASE, 8'd0, 32'd0, 5'd4, 1, '{5'd4, 1'b0, ST_UNDER}});
        rows.push_back('{ACT_READ, 8'hFF, 32'hFFFF_FFFF, 5'd0, 0, '{default: '0}});
        rows.push_back('{ACT_READ, 8'hA5, 32'd13, 5'd0, 0, '{default: '0}});
        rows.push_back('{ACT_READ, 8'h5A, 32'd7, 5'd0, 0, '{default: '0}});
        rows.push_back('{ACT_READ, 8'h5A, 32'd7, 5'd0, 0, '{default: '0}});
        rows.push_back('{ACT_PIN, 8'd0, 32'd0, 5'd31, 0, '{default: '0}});
        rows.push_back('{ACT_UNPIN, 8'd0, 32'd0, 5'd31, 0, '{default: '0}});
        rows.push_back('{ACT_RELEASE, 8'd0, 32'd0, 5'd31, 0, '{default: '0}});
        rows.push_back('{ACT_RELEASE, 8'd0, 32'd0, 5'd31, 0, '{default: '0}});
        rows.push_back('{ACT_PIN, 8'd0, 32'd0, 5'd0, 0, '{default: '0}});
        rows.push_back('{ACT_UNPIN, 8'd0, 32'd0, 5'd0, 0, '{default: '0}});
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) begin
            r = rows[i];
            offer(r.act, r.dev, r.blk, r.idx, r.chk, r.want);
        end
        // Saturate entry 2: the 256th pin reports overflow, then drain it back down.
        quiet = 1'b1;
        for (int n = 0; n < 256; n++)
            offer(ACT_PIN, 8'd0, 32'd0, 5'd2, n == 255, '{5'd2, 1'b0, ST_OVER});
        for (int n = 0; n < 255; n++) offer(ACT_UNPIN, 8'd0, 32'd0, 5'd2, 0, '{default: '0});
        quiet = 1'b0;
        // Hold every entry, then ask for a new block: no free buffer.
        for (int k = 0; k < NPOOL; k++)
            if (pool_cnt[k] == 0) offer(ACT_PIN, 8'd0, 32'd0, k[4:0], 0, '{default: '0});
        offer(ACT_READ, 8'h77, 32'd12345, 5'd0, 1, '{5'd0, 1'b0, ST_NOFREE});
        for (int k = 0; k < NPOOL; k++)
            while (pool_cnt[k] != 0) offer(ACT_RELEASE, 8'd0, 32'd0, k[4:0], 0, '{default: '0});
        // Random traffic: mostly reads with matching releases, plus pin/unpin noise.
        for (int n = 0; n < 160; n++) begin
            if (n == 40) fork
                begin hold_off = 1'b1; repeat (200) @(posedge i_clk); hold_off = 1'b0; end
            join_none
            quiet = (n >= 80 && n < 130);
            p = $urandom_range(99);
            if (p < 45 || held.size() == 0) begin
                offer(ACT_READ, $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(1)),
                      pick_block(), 5'($urandom()), 0, '{default: '0});
                if (grant_q[$].stat != ST_NOFREE && held.size() < 40)
                    held.push_back(grant_q[$].gidx);
            end else if (p < 80) begin
                p = $urandom_range(held.size() - 1);
                offer(ACT_RELEASE, 8'($urandom()), $urandom(), held[p][4:0], 0, '{default: '0});
                held.delete(p);
            end else
                offer(p < 90 ? ACT_PIN : ACT_UNPIN, 8'($urandom()), $urandom(),
                      5'($urandom()), 0, '{default: '0});
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // Receiver: random stalls plus the long hold-off, checks on every result transfer.
    always @(negedge i_clk)
        o_ready <= !hold_off && (quiet || $urandom_range(99) >= 14);

    always @(posedge i_clk) begin
        t_grant w;
        if (i_rst_n && o_valid && o_ready) begin
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", o_granted_index);
            end else begin
                w = grant_q.pop_front();
                if (w.gidx !== o_granted_index || w.fill !== o_need_fill ||
                    w.stat !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected idx %0d fill %0d status %0d, got %0d %0d %0d",
                                 w.gidx, w.fill, w.stat, o_granted_index, o_need_fill, o_status);
                end
            end
        end
    end

    initial begin
        wait (sender_done && grant_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end
endmodule
